### design/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

  localparam int unsigned Rounds     = 10;
  localparam int unsigned SchedWords = 44;

  typedef enum logic [1:0] {
    KeyIdle,
    KeyRun
  } key_state_e;

  typedef enum logic [1:0] {
    EncIdle,
    EncRound,
    EncDone
  } enc_state_e;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic       busy;
    logic       we;
    logic [5:0] waddr;
    logic [31:0] wdata;
  } sched_wr_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int k = 0; k < 16; k++) begin
      b[k] = sbox(s[127-8*k -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c+r] = b[4*((c+r)%4)+r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      if (!last) begin
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int k = 0; k < 16; k++) begin
      o[127-8*k -: 8] = t[k];
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### design/aes_keyexp.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_keyexp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [127:0]      key_i,
  output aes_pkg::sched_wr_t     wr_o
);
  import aes_pkg::*;

  key_state_e state_q, state_d;
  logic [5:0]   idx_q, idx_d;
  logic [127:0] win_q, win_d;
  logic [31:0]  t, nw;
  logic [3:0]   rnd;

  // window holds the last four words, oldest in the high bits
  always_comb begin
    rnd = idx_q[5:2];
    t   = win_q[31:0];
    if (idx_q[1:0] == 2'd0) begin
      t = sub_word({t[23:0], t[31:24]}) ^ {rcon(rnd), 24'h0};
    end
    nw = win_q[127:96] ^ t;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    win_d   = win_q;
    wr_o.busy  = (state_q == KeyRun);
    wr_o.we    = 1'b0;
    wr_o.waddr = idx_q;
    wr_o.wdata = nw;
    unique case (state_q)
      KeyIdle: begin
        if (start_i) begin
          state_d = KeyRun;
          idx_d   = 6'd0;
          win_d   = key_i;
        end
      end
      KeyRun: begin
        wr_o.we = 1'b1;
        if (idx_q < 6'd4) begin
          wr_o.wdata = win_q[127-32*idx_q[1:0] -: 32];
          if (idx_q == 6'd3) begin
            idx_d = 6'd4;
          end else begin
            idx_d = idx_q + 6'd1;
          end
        end else begin
          win_d = {win_q[95:0], nw};
          idx_d = idx_q + 6'd1;
          if (idx_q == 6'(SchedWords - 1)) begin
            state_d = KeyIdle;
          end
        end
        if (start_i) begin
          idx_d   = 6'd0;
          win_d   = key_i;
          state_d = KeyRun;
        end
      end
      default: state_d = KeyIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KeyRun;
      idx_q   <= 6'd0;
      win_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      win_q   <= win_d;
    end
  end
endmodule
`default_nettype wire

### design/aes_round_core.sv
`timescale 1ns / 1ps
`default_nettype none
module aes_round_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  aes_pkg::sched_wr_t     wr_i,
  input  wire logic              start_i,
  input  wire logic [127:0]      block_i,
  input  wire logic              out_ready_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [127:0]           result_o
);
  import aes_pkg::*;

  logic [127:0] rk_mem [11];
  logic [127:0] rk_rd_q;
  logic [31:0]  wbuf_q [3];

  enc_state_e   state_q, state_d;
  logic [3:0]   rnd_q, rnd_d;
  logic [127:0] st_q, st_d;
  logic [3:0]   rd_addr;

  // collect three words, write the round key with the fourth
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      unique case (wr_i.waddr[1:0])
        2'd0: wbuf_q[0] <= wr_i.wdata;
        2'd1: wbuf_q[1] <= wr_i.wdata;
        2'd2: wbuf_q[2] <= wr_i.wdata;
        2'd3: rk_mem[wr_i.waddr[5:2]] <= {wbuf_q[0], wbuf_q[1], wbuf_q[2], wr_i.wdata};
        default: ;
      endcase
    end
    rk_rd_q <= rk_mem[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    st_d    = st_q;
    rd_addr = rnd_q;
    done_o  = 1'b0;
    unique case (state_q)
      EncIdle: begin
        rd_addr = 4'd0;
        if (start_i) begin
          state_d = EncRound;
          rnd_d   = 4'd0;
          st_d    = block_i;
        end
      end
      EncRound: begin
        rd_addr = (rnd_q == 4'(Rounds)) ? 4'd0 : rnd_q + 4'd1;
        if (rnd_q == 4'd0) begin
          st_d = st_q ^ rk_rd_q;
        end else begin
          st_d = round_fn(st_q, rnd_q == 4'(Rounds)) ^ rk_rd_q;
        end
        if (rnd_q == 4'(Rounds)) begin
          state_d = EncDone;
        end else begin
          rnd_d = rnd_q + 4'd1;
        end
      end
      EncDone: begin
        done_o = 1'b1;
        if (out_ready_i) begin
          state_d = EncIdle;
        end
      end
      default: state_d = EncIdle;
    endcase
  end

  assign busy_o   = (state_q != EncIdle);
  assign result_o = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EncIdle;
      rnd_q   <= 4'd0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      st_q    <= st_d;
    end
  end
endmodule
`default_nettype wire

### design/aes128_block_encrypt.sv
// From an accepted item to result valid the core does one key add, then ten rounds.
// A new item waits until the last result is taken; the shared round unit runs one
// round per cycle, reading one 128-bit round key per cycle from the round-key memory.
// Reset: key registers clear to zero and the 44-word schedule is expanded,
// one word per cycle; no item is accepted until that and any rekey finish.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_encrypt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] plain_high_i,
  input  wire logic [63:0] plain_low_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      cipher_high_o,
  output logic [63:0]      cipher_low_o
);
  import aes_pkg::*;

  logic [63:0] key_high_q, key_low_q;
  logic [127:0] key_new;
  logic        rekey;
  sched_wr_t   wr;
  logic        core_busy;
  logic [127:0] result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgKeyHigh: key_high_q <= cfg_data_i;
        CfgKeyLow:  key_low_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rekey   = cfg_we_i;
  assign key_new = (cfg_index_e'(cfg_index_i) == CfgKeyHigh) ? {cfg_data_i, key_low_q}
                                                              : {key_high_q, cfg_data_i};

  aes_keyexp u_keyexp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rekey),
    .key_i   (key_new),
    .wr_o    (wr)
  );

  assign in_ready_o = !core_busy && !wr.busy && !rekey;

  aes_round_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .start_i     (in_valid_i && in_ready_o),
    .block_i     ({plain_high_i, plain_low_i}),
    .out_ready_i (out_ready_i),
    .busy_o      (core_busy),
    .done_o      (out_valid_o),
    .result_o    (result)
  );

  assign cipher_high_o = result[127:64];
  assign cipher_low_o  = result[63:0];

`ifndef SYNTH
  a_no_accept_in_keyexp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.busy |-> !in_ready_o) else $error("item taken during key expansion");
  a_out_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input open while result pending");
  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(result)))
    else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

### sim/tb_aes128_block_encrypt.sv
`timescale 1ns / 1ps
module tb_aes128_block_encrypt;
  import aes_pkg::*;

  localparam int unsigned IdleLimit = 5000;

  typedef struct {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    bit          known;
    logic [127:0] ct;
  } vec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] plain_high_i;
  logic [63:0] plain_low_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  bit [7:0] sb [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  bit [63:0]  cur_key_hi;
  bit [63:0]  cur_key_lo;
  bit [31:0]  sched [44];
  logic [127:0] cipher_q [$];
  int         errors;
  int         idle_cycles;
  int         hold_cycles;
  int         ready_mode;

  aes128_block_encrypt dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit [7:0] dbl(bit [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic void build_schedule();
    bit [31:0] t;
    bit [7:0]  rc;
    sched[0] = cur_key_hi[63:32];
    sched[1] = cur_key_hi[31:0];
    sched[2] = cur_key_lo[63:32];
    sched[3] = cur_key_lo[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb[t[31:24]] ^ rc, sb[t[23:16]], sb[t[15:8]], sb[t[7:0]]};
        rc = dbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
  endfunction

  function automatic bit [127:0] encrypt_block(bit [127:0] pt);
    bit [7:0]   st [16];
    bit [7:0]   sh [16];
    bit [7:0]   a0, a1, a2, a3, al;
    bit [127:0] ct;
    for (int k = 0; k < 16; k++) begin
      st[k] = pt[127-8*k -: 8] ^ sched[k/4][31-8*(k%4) -: 8];
    end
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int w = 0; w < 4; w++) begin
          sh[4*c+w] = sb[st[4*((c+w)%4)+w]];
        end
      end
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        if (r < 10) begin
          sh[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
          sh[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
          sh[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
          sh[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
        end
      end
      for (int k = 0; k < 16; k++) begin
        st[k] = sh[k] ^ sched[4*r + k/4][31-8*(k%4) -: 8];
      end
    end
    for (int k = 0; k < 16; k++) begin
      ct[127-8*k -: 8] = st[k];
    end
    return ct;
  endfunction

  task automatic drain();
    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_key(cfg_index_e idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == CfgKeyHigh) cur_key_hi = val;
    else cur_key_lo = val;
    build_schedule();
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    in_valid_i <= 1'b0;
    drain();
    write_key(CfgKeyHigh, hi);
    write_key(CfgKeyLow, lo);
  endtask

  // offer one item, hold until taken, then maybe idle
  task automatic send_block(logic [63:0] hi, logic [63:0] lo, bit known, logic [127:0] ct,
                            inout int burst_left);
    in_valid_i   <= 1'b1;
    plain_high_i <= hi;
    plain_low_i  <= lo;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cipher_q = {cipher_q, (known ? ct : encrypt_block({hi, lo}))};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o || out_valid_o && out_ready_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("%t timeout", $time);
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cipher_q.size() == 0) begin
        $display("%t unexpected result %h %h", $time, cipher_high_o, cipher_low_o);
        errors++;
      end else begin
        if (cipher_high_o !== cipher_q[0][127:64]) begin
          $display("%t cipher_high exp %h got %h", $time, cipher_q[0][127:64], cipher_high_o);
          errors++;
        end
        if (cipher_low_o !== cipher_q[0][63:0]) begin
          $display("%t cipher_low exp %h got %h", $time, cipher_q[0][63:0], cipher_low_o);
          errors++;
        end
        void'(cipher_q.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 3) != 0;
        2: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  vec_t dir [] = '{
    '{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{64'h0, 64'h0, '1, '1, 1'b0, 128'h0},
    '{64'h0, 64'h0, 64'h8000000000000000, 64'h1, 1'b0, 128'h0},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f,
      64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0, 1'b0, 128'h0},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
      64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1, 128'h3925841d02dc09fbdc118597196a0b32},
    '{'1, '1, 64'h0, 64'h0, 1'b0, 128'h0},
    '{'1, '1, '1, '1, 1'b0, 128'h0},
    '{'1, 64'h0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 128'h0},
    '{64'h0, '1, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 128'h0},
    '{64'h0, 64'h0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 128'h0}
  };

  initial begin
    int burst_left;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CfgKeyHigh;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    plain_high_i <= '0;
    plain_low_i  <= '0;
    out_ready_i  <= 1'b1;
    errors       = 0;
    idle_cycles  = 0;
    hold_cycles  = 0;
    ready_mode   = 0;
    burst_left   = 0;
    cur_key_hi   = '0;
    cur_key_lo   = '0;
    build_schedule();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first rows run on the reset key, no write
    foreach (dir[i]) begin
      if (dir[i].key_hi != cur_key_hi || dir[i].key_lo != cur_key_lo)
        load_key(dir[i].key_hi, dir[i].key_lo);
      send_block(dir[i].pt_hi, dir[i].pt_lo, dir[i].known, dir[i].ct, burst_left);
    end

    hold_cycles = 300;
    for (int n = 0; n < 700; n++) begin
      logic [63:0] hi, lo;
      if (n % 100 == 50) begin
        case ($urandom_range(0, 3))
          0: load_key('0, '1);
          1: load_key('1, {$urandom, $urandom});
          default: load_key({$urandom, $urandom}, {$urandom, $urandom});
        endcase
      end
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      case ($urandom_range(0, 15))
        0: hi = '0;
        1: lo = '1;
        default: ;
      endcase
      send_block(hi, lo, 1'b0, '0, burst_left);
    end
    in_valid_i <= 1'b0;

    while (cipher_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
